### sv/sraa_pkg.sv
// ----------------------------------------------------------------------------
// Sensor running average alarm package
// Shared constants, codes and types of the sensor alarm unit.
// ----------------------------------------------------------------------------
package sraa_pkg;

  localparam int MAX_SENSORS_DEF   = 64;
  localparam int WINDOW_LENGTH_DEF = 5;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_MEAS  = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [1:0] CFG_MIN_TEMP = 2'd0;
  localparam logic [1:0] CFG_MAX_TEMP = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_MEAS,
    OP_QUERY
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SRD,
    S_SCMP,
    S_SUM,
    S_DIV,
    S_WB,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [15:0]        probe_id;
    logic [15:0]        room_number;
    logic signed [15:0] reading;
    logic [31:0]        stamp;
  } item_t;

endpackage

### sv/sraa_in_if.sv
// ----------------------------------------------------------------------------
// Sensor alarm input channel
// Valid/ready channel that carries one sensor command per transfer.
// ----------------------------------------------------------------------------
interface sraa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [15:0]        probe_id;
  logic [15:0]        room_number;
  logic signed [15:0] reading;
  logic [31:0]        stamp;

  modport source(output valid, action, probe_id, room_number, reading, stamp, input ready);
  modport sink(input valid, action, probe_id, room_number, reading, stamp, output ready);
endinterface

### sv/sraa_out_if.sv
// ----------------------------------------------------------------------------
// Sensor alarm result channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface sraa_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [15:0]        room_out;
  logic signed [15:0] average_out;
  logic               too_cold;
  logic               too_hot;
  logic [31:0]        last_stamp;

  modport source(output valid, status, room_out, average_out, too_cold, too_hot, last_stamp,
                 input ready);
  modport sink(input valid, status, room_out, average_out, too_cold, too_hot, last_stamp,
               output ready);
endinterface

### sv/sraa_front.sv
// ----------------------------------------------------------------------------
// Sensor alarm front end
// Accepts commands, decodes the action and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sraa_front (
  input  logic           clk,
  input  logic           rst_n,
  sraa_in_if.sink        in_ch,
  output logic           q_valid,
  output sraa_pkg::item_t q_item,
  input  logic           q_ready
);
  import sraa_pkg::*;

  item_t      slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;
  item_t      dec;

  always_comb begin
    case (in_ch.action)
      ACT_LOAD: dec.op = OP_LOAD;
      ACT_MEAS: dec.op = OP_MEAS;
      default:  dec.op = OP_QUERY;
    endcase
    dec.probe_id    = in_ch.probe_id;
    dec.room_number = in_ch.room_number;
    dec.reading     = in_ch.reading;
    dec.stamp       = in_ch.stamp;
  end

  assign in_ch.ready = (fill_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill_r != 2'd0);
  assign q_item      = slot_r[rptr_r];
  assign pop         = q_valid && q_ready;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    fill_nxt = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= dec;
    end
  end
endmodule

### sv/sraa_back.sv
// ----------------------------------------------------------------------------
// Sensor alarm back end
// Sequencer that searches the sensor table, updates windows and averages,
// and delivers results through an output register.
// ----------------------------------------------------------------------------
module sraa_back #(
  parameter int MAX_SENSORS   = sraa_pkg::MAX_SENSORS_DEF,
  parameter int WINDOW_LENGTH = sraa_pkg::WINDOW_LENGTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  sraa_pkg::item_t q_item,
  output logic            q_ready,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_idx,
  input  logic [15:0]     cfg_wdata,
  sraa_out_if.source      out_ch
);
  import sraa_pkg::*;

  localparam int AW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CW = $clog2(MAX_SENSORS + 1);
  localparam int WW = WINDOW_LENGTH * 16;
  localparam int SW = 17 + $clog2(WINDOW_LENGTH);
  localparam int KW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int RS = 24;
  localparam int PW = SW + RS + 1;
  localparam logic [RS:0] RECIP = (RS+1)'((2**RS + WINDOW_LENGTH - 1) / WINDOW_LENGTH);

  logic [15:0] id_mem    [MAX_SENSORS];
  logic [15:0] room_mem  [MAX_SENSORS];
  logic [15:0] avg_mem   [MAX_SENSORS];
  logic [31:0] stamp_mem [MAX_SENSORS];
  logic [WW-1:0] win_mem [MAX_SENSORS];

  logic [15:0]   id_q, room_q, avg_q;
  logic [31:0]   stamp_q;
  logic [WW-1:0] win_q;

  state_t state_r, state_nxt;
  item_t  item_r, item_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [WW-1:0] nwin_r, nwin_nxt;
  logic [WW-1:0] sh_r, sh_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic          zero_r, zero_nxt;
  logic          neg_r, neg_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [SW-1:0] dvd_r, dvd_nxt;
  logic [1:0]    rs_status_r, rs_status_nxt;
  logic [15:0]   rs_room_r, rs_room_nxt;
  logic [15:0]   rs_avg_r, rs_avg_nxt;
  logic [31:0]   rs_stamp_r, rs_stamp_nxt;
  logic signed [15:0] min_temp_r, max_temp_r;
  logic          ov_r, ov_nxt;
  logic [1:0]    o_status_r;
  logic [15:0]   o_room_r, o_avg_r;
  logic [31:0]   o_stamp_r;
  logic          o_cold_r, o_hot_r;

  logic          load_out;
  logic          wr_entry, wr_load;
  logic [AW-1:0] wr_addr;
  logic [PW-1:0] prod;
  logic [15:0]   quo;
  logic signed [15:0] slot;
  logic signed [15:0] res_avg_s;

  // The magnitude of the window sum is divided by a reciprocal multiplication.
  assign slot      = sh_r[15:0];
  assign prod      = PW'(dvd_r) * PW'(RECIP);
  assign quo       = prod[RS +: 16];
  assign res_avg_s = rs_avg_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    scan_nxt      = scan_r;
    idx_nxt       = idx_r;
    nwin_nxt      = nwin_r;
    sh_nxt        = sh_r;
    sum_nxt       = sum_r;
    zero_nxt      = zero_r;
    neg_nxt       = neg_r;
    k_nxt         = k_r;
    dvd_nxt       = dvd_r;
    rs_status_nxt = rs_status_r;
    rs_room_nxt   = rs_room_r;
    rs_avg_nxt    = rs_avg_r;
    rs_stamp_nxt  = rs_stamp_r;
    ov_nxt        = ov_r;
    q_ready       = 1'b0;
    load_out      = 1'b0;
    wr_load       = 1'b0;
    wr_entry      = 1'b0;
    wr_addr       = idx_r;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          item_nxt = q_item;
          scan_nxt = '0;
          state_nxt = (q_item.op == OP_LOAD) ? S_LOAD : S_SRD;
        end
      end
      S_LOAD: begin
        wr_addr = cnt_r[AW-1:0];
        if (cnt_r == CW'(MAX_SENSORS)) begin
          rs_status_nxt = ST_FULL;
          rs_room_nxt   = '0;
          rs_avg_nxt    = '0;
          rs_stamp_nxt  = '0;
        end else begin
          wr_load       = 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
          rs_status_nxt = ST_OK;
          rs_room_nxt   = item_r.room_number;
          rs_avg_nxt    = '0;
          rs_stamp_nxt  = item_r.stamp;
        end
        state_nxt = S_DONE;
      end
      S_SRD: begin
        if (scan_r == cnt_r) begin
          rs_status_nxt = ST_UNKNOWN;
          rs_room_nxt   = '0;
          rs_avg_nxt    = '0;
          rs_stamp_nxt  = '0;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (id_q == item_r.probe_id) begin
          idx_nxt       = scan_r[AW-1:0];
          rs_status_nxt = ST_OK;
          rs_room_nxt   = room_q;
          if (item_r.op == OP_MEAS) begin
            nwin_nxt  = (win_q >> 16) |
                        (WW'($unsigned(item_r.reading)) << ((WINDOW_LENGTH - 1) * 16));
            sh_nxt    = nwin_nxt;
            sum_nxt   = '0;
            zero_nxt  = 1'b0;
            k_nxt     = '0;
            state_nxt = S_SUM;
          end else begin
            rs_avg_nxt   = avg_q;
            rs_stamp_nxt = stamp_q;
            state_nxt    = S_DONE;
          end
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SUM: begin
        sum_nxt  = sum_r + SW'(slot);
        zero_nxt = zero_r || (slot == 16'sd0);
        sh_nxt   = sh_r >> 16;
        k_nxt    = k_r + 1'b1;
        if (k_r == KW'(WINDOW_LENGTH - 1)) begin
          k_nxt = '0;
          state_nxt = S_DIV;
          if (zero_nxt) begin
            rs_avg_nxt = '0;
            state_nxt  = S_WB;
          end else begin
            neg_nxt = sum_nxt[SW-1];
            dvd_nxt = sum_nxt[SW-1] ? SW'(-sum_nxt) : SW'(sum_nxt);
          end
        end
      end
      S_DIV: begin
        rs_avg_nxt = neg_r ? (16'd0 - quo) : quo;
        state_nxt  = S_WB;
      end
      S_WB: begin
        wr_entry     = 1'b1;
        rs_stamp_nxt = item_r.stamp;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          load_out  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      ov_r       <= 1'b0;
      min_temp_r <= '0;
      max_temp_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we && cfg_idx == CFG_MIN_TEMP) begin
        min_temp_r <= cfg_wdata;
      end
      if (cfg_we && cfg_idx == CFG_MAX_TEMP) begin
        max_temp_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    scan_r      <= scan_nxt;
    idx_r       <= idx_nxt;
    nwin_r      <= nwin_nxt;
    sh_r        <= sh_nxt;
    sum_r       <= sum_nxt;
    zero_r      <= zero_nxt;
    neg_r       <= neg_nxt;
    k_r         <= k_nxt;
    dvd_r       <= dvd_nxt;
    rs_status_r <= rs_status_nxt;
    rs_room_r   <= rs_room_nxt;
    rs_avg_r    <= rs_avg_nxt;
    rs_stamp_r  <= rs_stamp_nxt;
    if (load_out) begin
      o_status_r <= rs_status_r;
      o_room_r   <= rs_room_r;
      o_avg_r    <= rs_avg_r;
      o_stamp_r  <= rs_stamp_r;
      o_cold_r   <= (res_avg_s != 16'sd0) && (res_avg_s <= min_temp_r);
      o_hot_r    <= (res_avg_s != 16'sd0) && (res_avg_s >= max_temp_r);
    end
  end

  always_ff @(posedge clk) begin
    id_q    <= id_mem[scan_r[AW-1:0]];
    room_q  <= room_mem[scan_r[AW-1:0]];
    avg_q   <= avg_mem[scan_r[AW-1:0]];
    stamp_q <= stamp_mem[scan_r[AW-1:0]];
    win_q   <= win_mem[scan_r[AW-1:0]];
    if (wr_load) begin
      id_mem[wr_addr]    <= item_r.probe_id;
      room_mem[wr_addr]  <= item_r.room_number;
      avg_mem[wr_addr]   <= '0;
      stamp_mem[wr_addr] <= item_r.stamp;
      win_mem[wr_addr]   <= '0;
    end else if (wr_entry) begin
      avg_mem[wr_addr]   <= rs_avg_r;
      stamp_mem[wr_addr] <= item_r.stamp;
      win_mem[wr_addr]   <= nwin_r;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.status      = o_status_r;
  assign out_ch.room_out    = o_room_r;
  assign out_ch.average_out = o_avg_r;
  assign out_ch.too_cold    = o_cold_r;
  assign out_ch.too_hot     = o_hot_r;
  assign out_ch.last_stamp  = o_stamp_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SENSORS))
    else $error("entry count beyond table size");

  a_match_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCMP) |-> (scan_r < cnt_r))
    else $error("compare on an entry that was never loaded");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && rs_status_nxt == ST_FULL) |=> (cnt_r == CW'(MAX_SENSORS)))
    else $error("table full reported while entries remain");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !q_ready)
    else $error("queue popped while an item is in work");
endmodule

### sv/sensor_running_average_alarm_unit.sv
// ----------------------------------------------------------------------------
// Sensor running average alarm unit
// Per-sensor moving average with cold and hot threshold flags.
// ----------------------------------------------------------------------------
// Commands arrive on in_ch (load, measurement, query) and each produces one
// result on out_ch; a transfer takes place when valid and ready are both high.
// The thresholds min_temp and max_temp are written through cfg_we, cfg_idx and
// cfg_wdata, which the user must do only while the unit is idle (not enforced).
// A two-entry queue decouples command intake from the sequencer, and the
// result sits in an output register, so a stalled receiver only stops the
// sequencer once a second result is ready.
// Items are worked on one at a time: the sequencer takes no new item from the queue until the last result is loaded.
// A transfer is written into the queue before the sequencer can take it; a
// load then passes S_LOAD and S_DONE to the output register. Queries and
// measurements scan the table entry by entry through a read state and a
// compare state; a measurement that hits adds a summing state over the window
// slots, a divide state and a write-back state, with no divide state when the
// window holds a zero. A miss ends the scan once every loaded entry is compared.
// Synchronous reset empties the table and the queue and clears thresholds.
module sensor_running_average_alarm_unit #(
  parameter int MAX_SENSORS   = sraa_pkg::MAX_SENSORS_DEF,
  parameter int WINDOW_LENGTH = sraa_pkg::WINDOW_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sraa_in_if.sink     in_ch,
  sraa_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);
  import sraa_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  sraa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  sraa_back #(
    .MAX_SENSORS   (MAX_SENSORS),
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );
endmodule
